/* sv/cot_pkg.sv */
// Shared constants, types and helpers for the capsule overlap pipeline.
// Used by the channel interfaces and every module of the block.
package cot_pkg;

   // Input point and radius formats
   localparam int COORD_BITS  = 21;
   localparam int POINT_BITS  = 3 * COORD_BITS;
   localparam int RADIUS_BITS = 20;
   localparam int RADII_W     = RADIUS_BITS + 1;

   // Spine differences and dot products
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int DOT_W  = 2 * DIFF_W + 2;

   // Wide multiplier split into two halves over two stages
   localparam int MUL_W    = DOT_W + 2;
   localparam int MUL_HALF = MUL_W / 2;
   localparam int MUL_LAT  = 2;

   // Segment parameters s and t, unsigned Q.16 in [0,1]
   localparam int PARAM_FRAC = 16;
   localparam int PARAM_BITS = PARAM_FRAC + 1;
   localparam logic [PARAM_BITS-1:0] PARAM_ONE = PARAM_BITS'(1) << PARAM_FRAC;

   // Clamped fraction divider, one quotient bit per stage
   localparam int DIV_W     = 2 * MUL_W;
   localparam int DIV_STEPS = PARAM_FRAC;
   localparam int DIV_LAT   = DIV_STEPS + 1;

   // Second parameter numerator
   localparam int TN_W = DOT_W + PARAM_BITS + 1;

   // Closest-point difference, rounding and squares
   localparam int DV_W     = DIFF_W + PARAM_BITS + 2;
   localparam int RND_SH   = 12;
   localparam int M_W      = DV_W - RND_SH;
   localparam int SQ_W     = 2 * M_W + 2;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int SQRT_LAT = ROOT_W;

   // Gap output
   localparam int GAP_SH   = 4;
   localparam int GAP_W    = ROOT_W + 1 - GAP_SH;
   localparam int GAP_BITS = 22;
   localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

   // Pipeline depth and the stage where s and t are settled
   localparam int PIPE_LAT = 10 + MUL_LAT + 2 * DIV_LAT + SQRT_LAT;
   localparam int ST_IDX   = 5 + MUL_LAT + 2 * DIV_LAT;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d1;
      logic [2:0][DIFF_W-1:0] d2;
      logic [2:0][DIFF_W-1:0] r;
      logic [RADII_W-1:0]     radii;
   } geom_type;

   typedef struct packed {
      logic [DOT_W-1:0] a;
      logic [DOT_W-1:0] e;
      logic [DOT_W-1:0] b;
      logic [DOT_W-1:0] c;
      logic [DOT_W-1:0] f;
   } dots_type;

   typedef struct packed {
      geom_type geo;
      dots_type dots;
   } solve_type;

   typedef struct packed {
      geom_type              geo;
      logic                  tgt_t;
      logic [PARAM_BITS-1:0] s_fix;
      logic [PARAM_BITS-1:0] t_fix;
   } resolve_type;

   // Sign-extended coordinate k of a packed point
   function automatic logic signed [DIFF_W-1:0] coord(
      input logic [POINT_BITS-1:0] w, input int k);
      logic signed [COORD_BITS-1:0] v;
      v = w[k*COORD_BITS +: COORD_BITS];
      return DIFF_W'(v);
   endfunction

   // Exact 3-term dot product
   function automatic logic signed [DOT_W-1:0] dot3(
      input logic [2:0][DIFF_W-1:0] u, input logic [2:0][DIFF_W-1:0] v);
      logic signed [DOT_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         acc = acc + DOT_W'($signed(u[k])) * DOT_W'($signed(v[k]));
      end
      return acc;
   endfunction

endpackage

/* sv/cot_req_if.sv */
// Request channel: two capsules, valid/ready handshake.
// Depends on cot_pkg for field widths.
interface cot_req_if;
   logic                             valid;
   logic                             ready;
   logic [cot_pkg::POINT_BITS-1:0]   first_start;
   logic [cot_pkg::POINT_BITS-1:0]   first_end;
   logic [cot_pkg::RADIUS_BITS-1:0]  first_radius;
   logic [cot_pkg::POINT_BITS-1:0]   second_start;
   logic [cot_pkg::POINT_BITS-1:0]   second_end;
   logic [cot_pkg::RADIUS_BITS-1:0]  second_radius;

   modport source (output valid, first_start, first_end, first_radius,
                   second_start, second_end, second_radius, input ready);
   modport sink   (input valid, first_start, first_end, first_radius,
                   second_start, second_end, second_radius, output ready);
endinterface

/* sv/cot_rsp_if.sv */
// Response channel: overlap flag and spine gap, valid/ready handshake.
// Depends on cot_pkg for field widths.
interface cot_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          overlap;
   logic [cot_pkg::GAP_BITS-1:0]  gap;

   modport source (output valid, overlap, gap, input ready);
   modport sink   (input valid, overlap, gap, output ready);
endinterface

/* sv/cot_mul.sv */
// Two-stage signed wide multiplier built from four half-width products.
// Depends on cot_pkg for MUL_W and MUL_HALF.
module cot_mul (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [cot_pkg::MUL_W-1:0]   x,
   input  logic signed [cot_pkg::MUL_W-1:0]   y,
   output logic signed [2*cot_pkg::MUL_W-1:0] p
);
   localparam int W = cot_pkg::MUL_W;
   localparam int H = cot_pkg::MUL_HALF;

   logic [W-1:0]   mx, my;
   logic [2*H-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic           neg_ff;
   logic [2*W-1:0] mag_in;
   logic signed [2*W-1:0] p_ff;

   // Take magnitudes
   assign mx = x[W-1] ? (~x + 1'b1) : x;
   assign my = y[W-1] ? (~y + 1'b1) : y;

   // Stage one: partial products
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff  <= mx[H-1:0] * my[H-1:0];
         lh_ff  <= mx[H-1:0] * my[W-1:H];
         hl_ff  <= mx[W-1:H] * my[H-1:0];
         hh_ff  <= mx[W-1:H] * my[W-1:H];
         neg_ff <= x[W-1] ^ y[W-1];
      end
   end

   // Stage two: combine and restore sign
   assign mag_in = (2*W)'(ll_ff) + ((2*W)'(lh_ff) << H) + ((2*W)'(hl_ff) << H)
                 + ((2*W)'(hh_ff) << (2*H));

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= neg_ff ? -$signed(mag_in) : $signed(mag_in);
      end
   end

   assign p = p_ff;
endmodule

/* sv/cot_div.sv */
// Pipelined clamped fraction divider: clamp(num/den, 0, 1) in Q.16.
// Depends on cot_pkg; den must be positive.
module cot_div (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [cot_pkg::DIV_W-1:0]    num,
   input  logic [cot_pkg::DIV_W-1:0]           den,
   output logic [cot_pkg::PARAM_BITS-1:0]      quo
);
   localparam int W = cot_pkg::DIV_W;
   localparam int N = cot_pkg::DIV_STEPS;
   localparam int F = cot_pkg::PARAM_FRAC;

   logic [W-1:0] rem_ff [0:N];
   logic [W-1:0] den_ff [0:N];
   logic [F-1:0] q_ff   [0:N];
   logic [N:0]   zero_ff, one_ff;

   logic [W-1:0] shl    [1:N];
   logic [N:0]   take;
   logic [W-1:0] rem_in [1:N];
   logic [F-1:0] q_in   [1:N];
   logic         num_le0, num_ge;

   // Settle the clamp cases up front
   assign num_le0 = (num <= 0);
   assign num_ge  = !num_le0 && ($unsigned(num) >= den);

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= num_le0;
         one_ff[0]  <= num_ge;
         rem_ff[0]  <= (num_le0 || num_ge) ? '0 : $unsigned(num);
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
      end
   end

   // One restoring step per stage
   always_comb begin
      take[0] = 1'b0;
      for (int i = 1; i <= N; i++) begin
         shl[i]    = rem_ff[i-1] << 1;
         take[i]   = (shl[i] >= den_ff[i-1]);
         rem_in[i] = take[i] ? (shl[i] - den_ff[i-1]) : shl[i];
         q_in[i]   = {q_ff[i-1][F-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 1; i <= N; i++) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_ff[i-1];
            q_ff[i]    <= q_in[i];
            zero_ff[i] <= zero_ff[i-1];
            one_ff[i]  <= one_ff[i-1];
         end
      end
   end

   assign quo = one_ff[N]  ? cot_pkg::PARAM_ONE :
                zero_ff[N] ? '0 : {1'b0, q_ff[N]};
endmodule

/* sv/cot_sqrt.sv */
// Pipelined floor integer square root, one root bit per stage.
// Depends on cot_pkg for SQ_W, ROOT_W and REM_W.
module cot_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cot_pkg::SQ_W-1:0]      n,
   output logic [cot_pkg::ROOT_W-1:0]    root
);
   localparam int S = cot_pkg::SQ_W;
   localparam int R = cot_pkg::ROOT_W;
   localparam int M = cot_pkg::REM_W;

   logic [M-1:0] rem_ff  [0:R-1];
   logic [R-1:0] root_ff [0:R-1];
   logic [S-1:0] rest_ff [0:R-1];

   logic [M-1:0] rem_src  [0:R-1];
   logic [R-1:0] root_src [0:R-1];
   logic [S-1:0] rest_src [0:R-1];
   logic [M-1:0] cur      [0:R-1];
   logic [M-1:0] trial    [0:R-1];
   logic [R-1:0] fit;

   // Bring down two radicand bits, try the next root bit
   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rest_src[0] = n;
      for (int i = 1; i < R; i++) begin
         rem_src[i]  = rem_ff[i-1];
         root_src[i] = root_ff[i-1];
         rest_src[i] = rest_ff[i-1];
      end
      for (int i = 0; i < R; i++) begin
         cur[i]   = {rem_src[i][M-3:0], rest_src[i][S-1:S-2]};
         trial[i] = M'({root_src[i], 2'b01});
         fit[i]   = (cur[i] >= trial[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < R; i++) begin
            rem_ff[i]  <= fit[i] ? (cur[i] - trial[i]) : cur[i];
            root_ff[i] <= {root_src[i][R-2:0], fit[i]};
            rest_ff[i] <= rest_src[i] << 2;
         end
      end
   end

   assign root = root_ff[R-1];
endmodule

/* sv/capsule_overlap_test.sv */
// Capsule overlap test: closest distance between two capsule spines.
// Depends on cot_pkg, cot_req_if, cot_rsp_if, cot_mul, cot_div, cot_sqrt.
//
// Usage: each req item carries two capsules (spine start, end, radius); each
// rsp item returns the spine gap (Q22.0, saturated) and an overlap flag set
// when the gap is at most the sum of the radii. One rsp item per req item,
// in order.
// Depth: PIPE_LAT = 76 register stages; rsp valid rises once the accepted req
// item has passed through all of them.
// Throughput: one item per cycle while rsp is ready or holds no valid item.
// The depth is set by the two 17-stage parameter dividers, the 30-stage square
// root and the two-stage wide multipliers for the determinant and first numerator.
// Stall: the whole pipeline advances on one enable. When the rsp item waits
// unaccepted, every stage holds and req.ready drops; bubbles elsewhere do not
// lose or repeat items.
// Reset: synchronous, active high; clears all valid bits, so no rsp item is
// shown until fresh items have passed through.
module capsule_overlap_test (
   input  logic      clock,
   input  logic      reset,
   cot_req_if.sink   req,
   cot_rsp_if.source rsp
);
   localparam int LAT = cot_pkg::PIPE_LAT;

   logic           en;
   logic [LAT-1:0] vld_ff;

   // Advance all stages unless the output item is stuck
   assign en        = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   // S1: differences and summed radii
   cot_pkg::geom_type s1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_ff.d1[k] <= cot_pkg::coord(req.first_end, k)
                         - cot_pkg::coord(req.first_start, k);
            s1_ff.d2[k] <= cot_pkg::coord(req.second_end, k)
                         - cot_pkg::coord(req.second_start, k);
            s1_ff.r[k]  <= cot_pkg::coord(req.first_start, k)
                         - cot_pkg::coord(req.second_start, k);
         end
         s1_ff.radii <= cot_pkg::RADII_W'(req.first_radius)
                      + cot_pkg::RADII_W'(req.second_radius);
      end
   end

   // S2: dot products
   cot_pkg::solve_type s2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff.geo    <= s1_ff;
         s2_ff.dots.a <= cot_pkg::dot3(s1_ff.d1, s1_ff.d1);
         s2_ff.dots.e <= cot_pkg::dot3(s1_ff.d2, s1_ff.d2);
         s2_ff.dots.b <= cot_pkg::dot3(s1_ff.d1, s1_ff.d2);
         s2_ff.dots.c <= cot_pkg::dot3(s1_ff.d1, s1_ff.r);
         s2_ff.dots.f <= cot_pkg::dot3(s1_ff.d2, s1_ff.r);
      end
   end

   // Determinant and first numerator products
   logic signed [cot_pkg::MUL_W-1:0]   ma, me, mb, mc, mf;
   logic signed [2*cot_pkg::MUL_W-1:0] p_ae, p_bb, p_bf, p_ce;
   assign ma = cot_pkg::MUL_W'($signed(s2_ff.dots.a));
   assign me = cot_pkg::MUL_W'($signed(s2_ff.dots.e));
   assign mb = cot_pkg::MUL_W'($signed(s2_ff.dots.b));
   assign mc = cot_pkg::MUL_W'($signed(s2_ff.dots.c));
   assign mf = cot_pkg::MUL_W'($signed(s2_ff.dots.f));

   cot_mul u_mul_ae (.clock(clock), .en(en), .x(ma), .y(me), .p(p_ae));
   cot_mul u_mul_bb (.clock(clock), .en(en), .x(mb), .y(mb), .p(p_bb));
   cot_mul u_mul_bf (.clock(clock), .en(en), .x(mb), .y(mf), .p(p_bf));
   cot_mul u_mul_ce (.clock(clock), .en(en), .x(mc), .y(me), .p(p_ce));

   cot_pkg::solve_type md_ff [0:cot_pkg::MUL_LAT-1];
   always_ff @(posedge clock) begin
      if (en) begin
         md_ff[0] <= s2_ff;
         for (int i = 1; i < cot_pkg::MUL_LAT; i++) md_ff[i] <= md_ff[i-1];
      end
   end

   // S4: choose first divider operands
   cot_pkg::solve_type                 s4_ff;
   logic signed [cot_pkg::DIV_W-1:0]   den_s, num_s;
   logic                               gen_ok;
   logic signed [cot_pkg::DIV_W-1:0]   num1_ff;
   logic [cot_pkg::DIV_W-1:0]          den1_ff;
   assign den_s  = p_ae - p_bb;
   assign num_s  = p_bf - p_ce;
   assign gen_ok = (md_ff[cot_pkg::MUL_LAT-1].dots.a != '0)
                && (md_ff[cot_pkg::MUL_LAT-1].dots.e != '0) && (den_s > 0);

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff   <= md_ff[cot_pkg::MUL_LAT-1];
         num1_ff <= gen_ok ? num_s : '0;
         den1_ff <= gen_ok ? $unsigned(den_s) : cot_pkg::DIV_W'(1);
      end
   end

   logic [cot_pkg::PARAM_BITS-1:0] s_q;
   cot_div u_div_s (.clock(clock), .en(en), .num(num1_ff), .den(den1_ff), .quo(s_q));

   cot_pkg::solve_type dd1_ff [0:cot_pkg::DIV_LAT-1];
   always_ff @(posedge clock) begin
      if (en) begin
         dd1_ff[0] <= s4_ff;
         for (int i = 1; i < cot_pkg::DIV_LAT; i++) dd1_ff[i] <= dd1_ff[i-1];
      end
   end

   // S5: numerator of t from the quantized s
   cot_pkg::solve_type              s5_ff;
   logic signed [cot_pkg::TN_W-1:0] tn_ff;
   logic [cot_pkg::PARAM_BITS-1:0]  s5_s_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff   <= dd1_ff[cot_pkg::DIV_LAT-1];
         s5_s_ff <= s_q;
         tn_ff   <= cot_pkg::TN_W'($signed(dd1_ff[cot_pkg::DIV_LAT-1].dots.b))
                  * cot_pkg::TN_W'($signed({1'b0, s_q}))
                  + (cot_pkg::TN_W'($signed(dd1_ff[cot_pkg::DIV_LAT-1].dots.f))
                     <<< cot_pkg::PARAM_FRAC);
      end
   end

   // S6: pick the case and the second divider operands
   cot_pkg::resolve_type             s6_in, s6_ff;
   logic signed [cot_pkg::DIV_W-1:0] num2_in, num2_ff;
   logic [cot_pkg::DIV_W-1:0]        den2_in, den2_ff;
   logic signed [cot_pkg::DIV_W-1:0] wa, we, wb, wc, wf, we_sh, wtn;

   always_comb begin
      wa    = cot_pkg::DIV_W'($signed(s5_ff.dots.a));
      we    = cot_pkg::DIV_W'($signed(s5_ff.dots.e));
      wb    = cot_pkg::DIV_W'($signed(s5_ff.dots.b));
      wc    = cot_pkg::DIV_W'($signed(s5_ff.dots.c));
      wf    = cot_pkg::DIV_W'($signed(s5_ff.dots.f));
      we_sh = we <<< cot_pkg::PARAM_FRAC;
      wtn   = cot_pkg::DIV_W'(tn_ff);
      s6_in.geo   = s5_ff.geo;
      s6_in.tgt_t = 1'b1;
      s6_in.s_fix = '0;
      s6_in.t_fix = '0;
      num2_in     = '0;
      den2_in     = cot_pkg::DIV_W'(1);
      if (s5_ff.dots.a == '0 && s5_ff.dots.e == '0) begin
         // both spines are points
      end else if (s5_ff.dots.a == '0) begin
         num2_in = wf;
         den2_in = $unsigned(we);
      end else if (s5_ff.dots.e == '0) begin
         s6_in.tgt_t = 1'b0;
         num2_in     = -wc;
         den2_in     = $unsigned(wa);
      end else if (wtn < 0) begin
         s6_in.tgt_t = 1'b0;
         num2_in     = -wc;
         den2_in     = $unsigned(wa);
      end else if (wtn > we_sh) begin
         s6_in.tgt_t = 1'b0;
         s6_in.t_fix = cot_pkg::PARAM_ONE;
         num2_in     = wb - wc;
         den2_in     = $unsigned(wa);
      end else begin
         s6_in.s_fix = s5_s_ff;
         num2_in     = wtn;
         den2_in     = $unsigned(we_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff   <= s6_in;
         num2_ff <= num2_in;
         den2_ff <= den2_in;
      end
   end

   logic [cot_pkg::PARAM_BITS-1:0] q2;
   cot_div u_div_t (.clock(clock), .en(en), .num(num2_ff), .den(den2_ff), .quo(q2));

   cot_pkg::resolve_type dd2_ff [0:cot_pkg::DIV_LAT-1];
   always_ff @(posedge clock) begin
      if (en) begin
         dd2_ff[0] <= s6_ff;
         for (int i = 1; i < cot_pkg::DIV_LAT; i++) dd2_ff[i] <= dd2_ff[i-1];
      end
   end

   // S7: settle s and t, form the closest-point difference
   cot_pkg::resolve_type                    rs;
   logic [cot_pkg::PARAM_BITS-1:0]          s_sel, t_sel;
   logic signed [cot_pkg::DV_W-1:0]         dv_in [0:2];
   logic signed [cot_pkg::DV_W-1:0]         dv_ff [0:2];
   logic [cot_pkg::PARAM_BITS-1:0]          s7_s_ff, s7_t_ff;
   logic [cot_pkg::RADII_W-1:0]             rad7_ff;

   assign rs    = dd2_ff[cot_pkg::DIV_LAT-1];
   assign s_sel = rs.tgt_t ? rs.s_fix : q2;
   assign t_sel = rs.tgt_t ? q2 : rs.t_fix;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv_in[k] = (cot_pkg::DV_W'($signed(rs.geo.r[k])) <<< cot_pkg::PARAM_FRAC)
                  + cot_pkg::DV_W'($signed(rs.geo.d1[k]))
                    * cot_pkg::DV_W'($signed({1'b0, s_sel}))
                  - cot_pkg::DV_W'($signed(rs.geo.d2[k]))
                    * cot_pkg::DV_W'($signed({1'b0, t_sel}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) dv_ff[k] <= dv_in[k];
         s7_s_ff <= s_sel;
         s7_t_ff <= t_sel;
         rad7_ff <= rs.geo.radii;
      end
   end

   // S8: round magnitudes to 4 extra fraction bits
   logic [cot_pkg::DV_W-1:0] mag [0:2];
   logic [cot_pkg::DV_W-1:0] rnd [0:2];
   logic [cot_pkg::M_W-1:0]  m_ff [0:2];
   logic [cot_pkg::RADII_W-1:0] rad8_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = dv_ff[k][cot_pkg::DV_W-1] ? $unsigned(-dv_ff[k]) : $unsigned(dv_ff[k]);
         rnd[k] = mag[k] + (cot_pkg::DV_W'(1) << (cot_pkg::RND_SH - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) m_ff[k] <= rnd[k][cot_pkg::DV_W-1:cot_pkg::RND_SH];
         rad8_ff <= rad7_ff;
      end
   end

   // S9: squares
   logic [2*cot_pkg::M_W-1:0]   sq_ff [0:2];
   logic [cot_pkg::RADII_W-1:0] rad9_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= (2*cot_pkg::M_W)'(m_ff[k]) * (2*cot_pkg::M_W)'(m_ff[k]);
         end
         rad9_ff <= rad8_ff;
      end
   end

   // S10: sum of squares
   logic [cot_pkg::SQ_W-1:0]    sum_ff;
   logic [cot_pkg::RADII_W-1:0] rad10_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= cot_pkg::SQ_W'(sq_ff[0]) + cot_pkg::SQ_W'(sq_ff[1])
                   + cot_pkg::SQ_W'(sq_ff[2]);
         rad10_ff <= rad9_ff;
      end
   end

   logic [cot_pkg::ROOT_W-1:0] root;
   cot_sqrt u_sqrt (.clock(clock), .en(en), .n(sum_ff), .root(root));

   logic [cot_pkg::RADII_W-1:0] rd_ff [0:cot_pkg::SQRT_LAT-1];
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff[0] <= rad10_ff;
         for (int i = 1; i < cot_pkg::SQRT_LAT; i++) rd_ff[i] <= rd_ff[i-1];
      end
   end

   // S11: round root to Q.0 (integer), compare, saturate
   logic [cot_pkg::ROOT_W:0]     g8;
   logic [cot_pkg::GAP_W-1:0]    gap_full;
   logic                         ovl_ff;
   logic [cot_pkg::GAP_BITS-1:0] gap_ff;

   assign g8       = (cot_pkg::ROOT_W+1)'(root) + (cot_pkg::ROOT_W+1)'(8);
   assign gap_full = g8[cot_pkg::ROOT_W:cot_pkg::GAP_SH];

   always_ff @(posedge clock) begin
      if (en) begin
         ovl_ff <= (gap_full <= cot_pkg::GAP_W'(rd_ff[cot_pkg::SQRT_LAT-1]));
         gap_ff <= (gap_full > cot_pkg::GAP_W'(cot_pkg::GAP_MAX)) ?
                   cot_pkg::GAP_MAX : gap_full[cot_pkg::GAP_BITS-1:0];
      end
   end

   assign rsp.valid   = vld_ff[LAT-1];
   assign rsp.overlap = ovl_ff;
   assign rsp.gap     = gap_ff;

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp valid right after reset");

   // Radii are never negative, so a miss needs a nonzero gap
   a_miss_gap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.overlap |-> rsp.gap != '0)
      else $error("miss reported with zero gap");

   // Settled parameters stay within the segments
   a_param_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[cot_pkg::ST_IDX] |->
         s7_s_ff <= cot_pkg::PARAM_ONE && s7_t_ff <= cot_pkg::PARAM_ONE)
      else $error("segment parameter above one");
endmodule
